/* sv/lipr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipr_pkg
// Shared widths, register indexes and types of the linear-interpolation
// pitch resampler.
// ----------------------------------------------------------------------------
package lipr_pkg;

  // sample and phase formats
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_RUN     = 16;
  localparam int STEP_BITS   = 24;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_SHIFT  = 15;
  localparam int SKIP_BITS   = 8;

  // smallest step that keeps every run within MAX_RUN outputs
  localparam int MIN_STEP_I  = ((1 << FRAC_BITS) + MAX_RUN - 1) / MAX_RUN;
  localparam logic [STEP_BITS-1:0] MIN_STEP = STEP_BITS'(MIN_STEP_I);

  // run counter
  localparam int CNT_BITS = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_RUN - 1);

  // multiplier operand and product widths
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int MA_W   = SAMPLE_BITS + 2;
  localparam int MB_W   = ((FRAC_BITS > GAIN_BITS) ? FRAC_BITS : GAIN_BITS) + 1;
  localparam int P_W    = MA_W + MB_W;

  // phase sum and its integer carry
  localparam int NXT_W   = STEP_BITS + 1;
  localparam int CARRY_W = NXT_W - FRAC_BITS;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = (STEP_BITS > GAIN_BITS) ? STEP_BITS : GAIN_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(1);

  // multiplier control from the sequencer
  typedef struct packed {
    logic load;      // capture a new product
    logic sel_gain;  // 0: diff * frac, 1: y * gain
  } mul_ctl_t;

endpackage

/* sv/lipr_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipr_mul
// Shared signed multiplier with a registered product; used once for the
// interpolation term and once for the gain of every output.
// ----------------------------------------------------------------------------
module lipr_mul (
  input  logic                              clk,
  input  lipr_pkg::mul_ctl_t                ctl,
  input  logic signed [lipr_pkg::DIFF_W-1:0] diff_i,
  input  logic [lipr_pkg::FRAC_BITS-1:0]    frac_i,
  input  logic signed [lipr_pkg::MA_W-1:0]  y_i,
  input  logic [lipr_pkg::GAIN_BITS-1:0]    gain_i,
  output logic signed [lipr_pkg::P_W-1:0]   product_o
);
  import lipr_pkg::*;

  logic signed [MA_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;
  logic signed [P_W-1:0]  product_r;

  // operand select
  always_comb begin
    if (ctl.sel_gain) begin
      op_a = y_i;
      op_b = $signed(MB_W'(gain_i));
    end else begin
      op_a = MA_W'(diff_i);
      op_b = $signed(MB_W'(frac_i));
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      product_r <= P_W'(op_a) * P_W'(op_b);
    end
  end

  assign product_o = product_r;

endmodule

/* sv/linear_interp_pitch_resampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_pitch_resampler
// Linear-interpolation pitch resampler: an 8.16 phase accumulator walks
// between consecutive source samples, each output is interpolated, scaled
// by a Q1.15 gain and saturated.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  in_source_sample, in_final_sample
//   out      source     out_valid/out_stall out_sample, out_run_last,
//                                           out_note_done
//   cfg      sink       cfg_wr_en          cfg_index, cfg_wr_data
//
// Each output that an input causes passes through multiply, add, multiply,
// round/saturate and present, all through one shared multiplier; an input
// causes at most 16 outputs.
// in_stall is high after a run-starting input is accepted until its last output is taken.
// An output held by out_stall keeps the sequencer waiting in place.
// rst_n is synchronous; it clears the note state and restores the registers.
// ----------------------------------------------------------------------------
module linear_interp_pitch_resampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input requests
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lipr_pkg::SAMPLE_BITS-1:0] in_source_sample,
  input  logic                                 in_final_sample,
  // output requests
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lipr_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                 out_run_last,
  output logic                                 out_note_done,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [lipr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lipr_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
  import lipr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_I = 6'b000010,
    S_ADD   = 6'b000100,
    S_MUL_G = 6'b001000,
    S_SAT   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  localparam logic signed [P_W-1:0] FRAC_HALF = P_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [P_W-1:0] GAIN_HALF = P_W'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [P_W-1:0] SMAX = (P_W'(1) <<< (SAMPLE_BITS - 1)) - P_W'(1);
  localparam logic signed [P_W-1:0] SMIN = -(P_W'(1) <<< (SAMPLE_BITS - 1));
  localparam logic [CARRY_W-1:0] SKIP_MAX = CARRY_W'((1 << SKIP_BITS) - 1);

  state_t state_r, state_nxt;

  // configuration registers
  logic [STEP_BITS-1:0] step_cfg_r;
  logic [GAIN_BITS-1:0] gain_r;

  // note state
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic [SKIP_BITS-1:0]          skip_r;
  logic [FRAC_BITS-1:0]          phase_r;
  logic                          have_prev_r;
  logic                          finished_r;

  // per-item working registers
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic                          last_r;
  logic [STEP_BITS-1:0]          step_r;
  logic [FRAC_BITS-1:0]          frac_r;
  logic [NXT_W-1:0]              nxt_r;
  logic [CNT_BITS-1:0]           cnt_r;
  logic signed [MA_W-1:0]        y_r;

  // output registers
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_run_last_r;
  logic                          out_note_done_r;

  logic                          in_acc;
  logic                          out_acc;
  mul_ctl_t                      mul_ctl;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [P_W-1:0]         product;
  logic signed [P_W-1:0]         frac_rnd;
  logic signed [P_W-1:0]         gain_rnd;
  logic signed [MA_W-1:0]        y_nxt;
  logic [CARRY_W-1:0]            carry;
  logic [CARRY_W-1:0]            skip_wide;
  logic                          run_end;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_acc   = out_valid && !out_stall;

  assign out_sample    = out_sample_r;
  assign out_run_last  = out_run_last_r;
  assign out_note_done = out_note_done_r;

  // shared multiplier
  assign diff = DIFF_W'(cur_r) - DIFF_W'(prev_r);
  assign mul_ctl.load     = (state_r == S_MUL_I) || (state_r == S_MUL_G);
  assign mul_ctl.sel_gain = (state_r == S_MUL_G);

  lipr_mul u_mul (
    .clk       (clk),
    .ctl       (mul_ctl),
    .diff_i    (diff),
    .frac_i    (frac_r),
    .y_i       (y_r),
    .gain_i    (gain_r),
    .product_o (product)
  );

  // interpolated value and gain rounding
  assign frac_rnd = (product + FRAC_HALF) >>> FRAC_BITS;
  assign y_nxt    = MA_W'(prev_r) + frac_rnd[MA_W-1:0];
  assign gain_rnd = (product + GAIN_HALF) >>> GAIN_SHIFT;

  // phase carry and next skip count
  assign carry   = nxt_r[NXT_W-1:FRAC_BITS];
  assign run_end = (carry != '0) || (cnt_r == CNT_LAST);
  always_comb begin
    if (carry == '0) begin
      skip_wide = '0;
    end else if ((carry - CARRY_W'(1)) > SKIP_MAX) begin
      skip_wide = SKIP_MAX;
    end else begin
      skip_wide = carry - CARRY_W'(1);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !finished_r && have_prev_r && (skip_r == '0)) begin
          state_nxt = S_MUL_I;
        end
      end
      S_MUL_I: state_nxt = S_ADD;
      S_ADD:   state_nxt = S_MUL_G;
      S_MUL_G: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_nxt = out_run_last_r ? S_IDLE : S_MUL_I;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and note state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cfg_r  <= STEP_BITS'(65536);
      gain_r      <= GAIN_BITS'(32768);
      prev_r      <= '0;
      skip_r      <= '0;
      phase_r     <= '0;
      have_prev_r <= 1'b0;
      finished_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == REG_STEP) begin
          step_cfg_r <= cfg_wr_data[STEP_BITS-1:0];
        end else if (cfg_index == REG_GAIN) begin
          gain_r <= cfg_wr_data[GAIN_BITS-1:0];
        end
      end

      // input request: store, skip or start a run
      if (in_acc && !finished_r) begin
        if (!have_prev_r) begin
          prev_r      <= in_source_sample;
          have_prev_r <= 1'b1;
          finished_r  <= in_final_sample;
        end else if (skip_r != '0) begin
          prev_r     <= in_source_sample;
          skip_r     <= skip_r - SKIP_BITS'(1);
          finished_r <= in_final_sample;
        end else begin
          cnt_r <= '0;
        end
      end

      // output request taken
      if (out_acc) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (out_run_last_r) begin
          skip_r     <= skip_wide[SKIP_BITS-1:0];
          phase_r    <= nxt_r[FRAC_BITS-1:0];
          prev_r     <= cur_r;
          finished_r <= last_r;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r  <= in_source_sample;
      last_r <= in_final_sample;
      step_r <= (step_cfg_r < MIN_STEP) ? MIN_STEP : step_cfg_r;
      frac_r <= phase_r;
    end
    if (state_r == S_ADD) begin
      y_r   <= y_nxt;
      nxt_r <= NXT_W'(step_r) + NXT_W'(frac_r);
    end
    if (state_r == S_SAT) begin
      if (gain_rnd > SMAX) begin
        out_sample_r <= SMAX[SAMPLE_BITS-1:0];
      end else if (gain_rnd < SMIN) begin
        out_sample_r <= SMIN[SAMPLE_BITS-1:0];
      end else begin
        out_sample_r <= gain_rnd[SAMPLE_BITS-1:0];
      end
      out_run_last_r  <= run_end;
      out_note_done_r <= run_end && last_r;
    end
    if (out_acc) begin
      frac_r <= nxt_r[FRAC_BITS-1:0];
    end
  end

endmodule

/* sv/lipr_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipr_chk
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module lipr_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [lipr_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic                                 out_run_last,
  input logic                                 out_note_done
);
  import lipr_pkg::*;

  // a held output request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample)
      && $stable(out_run_last) && $stable(out_note_done))
    else $error("stalled output request changed");

  // no new input while an output is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while output pending");

  // note end only on the last output of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_note_done |-> out_run_last)
    else $error("note_done without run_last");

  // the note end is followed by silence
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_note_done |=> !out_valid)
    else $error("output after note end");

  // no output shows in the cycle after an input is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("output in cycle after input");

endmodule

bind linear_interp_pitch_resampler lipr_chk u_lipr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample    (out_sample),
  .out_run_last  (out_run_last),
  .out_note_done (out_note_done)
);

/* verif/linear_interp_pitch_resampler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_pitch_resampler_test
// Self-checking bench for the pitch resampler. Source samples go in through
// the valid/stall request channel. A behavioral predictor in the bench
// works out every interpolated, gain-scaled output. A checker compares each
// output request field by field with the oldest pending prediction. Step
// and gain are rewritten between phases while the block is idle. Both sides
// idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module linear_interp_pitch_resampler_test;
  import lipr_pkg::*;

  localparam int SETTLE_CYCLES = 16;   // margin after the queue of predicted outputs empties
  localparam int FINAL_CYCLES  = 100;  // longer than one full 16-output run
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   run_last;
    logic                   note_done;
  } out_req_t;

  // DUT ports; the driven inputs are known from time zero
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_source_sample = '0;
  logic                          in_final_sample = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_run_last;
  logic                          out_note_done;
  logic                          cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_STEP;
  logic [CFG_DATA_W-1:0]         cfg_wr_data = '0;

  // predictor copy of registers and note state
  logic [STEP_BITS-1:0]          step_reg;
  logic [GAIN_BITS-1:0]          gain_reg;
  logic signed [SAMPLE_BITS-1:0] prev_smp;
  logic [SKIP_BITS-1:0]          skip_cnt;
  logic [FRAC_BITS-1:0]          phase_frac;
  logic                          have_prev;
  logic                          note_ended;

  out_req_t pending_samples[$];
  out_req_t want;
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_seq = 0;
  int       hold_seen = 0;

  linear_interp_pitch_resampler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_sample (in_source_sample),
    .in_final_sample  (in_final_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_run_last     (out_run_last),
    .out_note_done    (out_note_done),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // interpolate between two samples, scale by the gain, saturate
  function automatic logic [SAMPLE_BITS-1:0] interp_gain(
    input logic signed [SAMPLE_BITS-1:0] prv,
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic [FRAC_BITS-1:0]          frac
  );
    longint hi, lo, y, g;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    y  = longint'(prv) + (((longint'(cur) - longint'(prv)) * longint'(frac)
         + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    g  = (y * longint'(gain_reg) + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    if (g > hi) g = hi;
    if (g < lo) g = lo;
    return SAMPLE_BITS'(g);
  endfunction

  // advance the phase for one source sample and queue the outputs it causes
  task automatic predict_resample(input logic [SAMPLE_BITS-1:0] smp, input logic fin);
    out_req_t             run_buf [MAX_RUN];
    logic [STEP_BITS-1:0] eff_step;
    logic [NXT_W-1:0]     nxt;
    logic [CARRY_W-1:0]   carry;
    logic [FRAC_BITS-1:0] frac;
    int                   n;
    if (note_ended) return;
    // first sample is only stored; a skipped sample just moves the pair on
    if (!have_prev || skip_cnt != 0) begin
      if (have_prev) skip_cnt = skip_cnt - 1'b1;
      have_prev = 1'b1;
      prev_smp  = smp;
      if (fin) note_ended = 1'b1;
      return;
    end
    eff_step = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    frac = phase_frac;
    n = 0;
    do begin
      run_buf[n].sample    = interp_gain(prev_smp, smp, frac);
      run_buf[n].run_last  = 1'b0;
      run_buf[n].note_done = 1'b0;
      n++;
      nxt   = NXT_W'(frac) + NXT_W'(eff_step);
      carry = nxt[NXT_W-1:FRAC_BITS];
      frac  = nxt[FRAC_BITS-1:0];
    end while (carry == 0 && n < MAX_RUN);
    // integer part beyond one source sample turns into skips, capped
    if (carry != 0)
      skip_cnt = (carry - 1 > 255) ? SKIP_BITS'(255) : SKIP_BITS'(carry - 1);
    else
      skip_cnt = '0;
    phase_frac = frac;
    prev_smp   = smp;
    run_buf[n-1].run_last = 1'b1;
    if (fin) begin
      run_buf[n-1].note_done = 1'b1;
      note_ended = 1'b1;
    end
    for (int i = 0; i < n; i++) pending_samples.push_back(run_buf[i]);
  endtask

  // offer one source sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_source_sample <= smp;
    in_final_sample  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_resample(smp, fin);
  endtask

  // stop offering and wait until every predicted output has come out
  task automatic drain_block(input int settle);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // write both registers; gain data carries random junk above bit 15
  task automatic write_config(input logic [STEP_BITS-1:0] step, input logic [GAIN_BITS-1:0] gain);
    drain_block(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_STEP;
    cfg_wr_data <= CFG_DATA_W'(step);
    @(posedge clk);
    step_reg = step;
    cfg_index   <= REG_GAIN;
    cfg_wr_data <= {CFG_DATA_W'($urandom) >> GAIN_BITS << GAIN_BITS} | CFG_DATA_W'(gain);
    @(posedge clk);
    gain_reg = gain;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: return SAMPLE_BITS'(int'($urandom_range(16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(11))
      0: return STEP_BITS'($urandom_range(MIN_STEP_I - 1, 0));
      1: return MIN_STEP;
      2: return {STEP_BITS{1'b1}};
      3: return STEP_BITS'($urandom);
      4: return STEP_BITS'(1 << FRAC_BITS);
      5, 6: return STEP_BITS'($urandom_range(3 << FRAC_BITS, 1 << FRAC_BITS));
      default: return STEP_BITS'($urandom_range(1 << FRAC_BITS, MIN_STEP_I));
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return {GAIN_BITS{1'b1}};
      2: return GAIN_BITS'(1 << GAIN_SHIFT);
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual sample %0d last %b done %b",
                 $time, out_sample, out_run_last, out_note_done);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (out_sample !== want.sample) begin
          $display("%0t: out_sample mismatch: expected %0d, actual %0d",
                   $time, $signed(want.sample), out_sample);
          errors++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: out_run_last mismatch: expected %b, actual %b",
                   $time, want.run_last, out_run_last);
          errors++;
        end
        if (out_note_done !== want.note_done) begin
          $display("%0t: out_note_done mismatch: expected %b, actual %b",
                   $time, want.note_done, out_note_done);
          errors++;
        end
      end
    end
  end

  // reset defaults: first sample only stored, then extreme samples at unit step
  task automatic test_reset_defaults();
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'shffff, 1'b0);
  endtask

  // steps below, at and just above the floor: full sixteen-output runs
  task automatic test_min_step();
    write_config('0, GAIN_BITS'(1 << GAIN_SHIFT));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    write_config(MIN_STEP - 1'b1, GAIN_BITS'(1 << GAIN_SHIFT));
    send_sample(16'sh7fff, 1'b0);
    write_config(MIN_STEP, GAIN_BITS'(1 << GAIN_SHIFT));
    send_sample(16'sh8000, 1'b0);
    write_config(MIN_STEP + 1'b1, GAIN_BITS'(1 << GAIN_SHIFT));
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh1234, 1'b0);
  endtask

  // gain extremes: saturation both ways, then zero gain
  task automatic test_gain_extremes();
    write_config(STEP_BITS'(3 << (FRAC_BITS - 1)), {GAIN_BITS{1'b1}});
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    write_config(STEP_BITS'(3 << (FRAC_BITS - 2)), '0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh4321, 1'b0);
  endtask

  // largest step: skip count pegs at its cap, so many samples pass silently
  task automatic test_large_step();
    write_config({STEP_BITS{1'b1}}, pick_gain());
    repeat (270) send_sample(pick_sample(), 1'b0);
  endtask

  // random configuration and samples under one idling mix
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    repeat (2) begin
      write_config(pick_step(), pick_gain());
      repeat (n_items) send_sample(pick_sample(), 1'b0);
    end
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_config(MIN_STEP, pick_gain());
    hold_seq++;
    repeat (12) send_sample(pick_sample(), 1'b0);
  endtask

  // final sample with outputs ends the note; later samples are ignored
  task automatic test_note_end();
    send_idle_pct  = 18;
    recv_stall_pct = 50;
    write_config(STEP_BITS'(1 << FRAC_BITS), pick_gain());
    while (!have_prev || skip_cnt != 0) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    repeat (4) send_sample(pick_sample(), 1'($urandom_range(1)));
  endtask

  // main sequence
  initial begin
    step_reg   = STEP_BITS'(1 << FRAC_BITS);
    gain_reg   = GAIN_BITS'(1 << GAIN_SHIFT);
    prev_smp   = '0;
    skip_cnt   = '0;
    phase_frac = '0;
    have_prev  = 1'b0;
    note_ended = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_min_step();
    test_gain_extremes();
    test_large_step();
    test_random_traffic(18, 78, 35);
    test_random_traffic(78, 18, 35);
    test_random_traffic(0, 0, 35);
    test_backpressure();
    test_note_end();

    drain_block(FINAL_CYCLES);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
